// File: rtl/julia_escape_time_top_defines.svh
// ----------------------------------------------------------------------------
// julia_escape_time_top_defines.svh
// Assertion macros shared by the julia escape-time block.
// ----------------------------------------------------------------------------
`ifndef JULIA_ESCAPE_TIME_TOP_DEFINES_SVH
`define JULIA_ESCAPE_TIME_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define JET_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");
`define JET_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define JET_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define JET_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/jet_pkg.sv
// ----------------------------------------------------------------------------
// jet_pkg
// Shared types and constants of the julia escape-time block.
// ----------------------------------------------------------------------------
package jet_pkg;

  localparam int unsigned CFG_ADDR_BITS = 4;
  localparam int unsigned ITER_BITS     = 17;

  localparam logic [1:0] REG_C_REAL   = 2'd0;
  localparam logic [1:0] REG_C_IMAG   = 2'd1;
  localparam logic [1:0] REG_MAX_ITER = 2'd2;

  localparam logic [31:0] C_REAL_RESET   = 32'hF4CCCCCD;
  localparam logic [31:0] C_IMAG_RESET   = 32'h0428F5C3;
  localparam logic [15:0] MAX_ITER_RESET = 16'd1000;

  typedef struct packed {
    logic [31:0] c_real;
    logic [31:0] c_imag;
    logic [15:0] max_iter;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic escape;
  } dp_status_t;

endpackage

// File: rtl/julia_escape_time_top.sv
// ----------------------------------------------------------------------------
// julia_escape_time_top
// Julia-set escape-time engine: iterates z = z*z + c on one point at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Configure c_real (0x0), c_imag (0x4) and max_iter (0x8) over the APB port
//   while the block is idle; pready is always high, reads return the value.
//   A point is taken on start while busy is low (in_z_real, in_z_imag, Q4.28).
//   One complex update runs per cycle through the three shared multipliers;
//   the same squares give |z|^2 of the previous update, so the escape test
//   is combinational and needs no extra multiplier. The result is
//   registered when the point escapes or reaches the iteration bound.
//   The result beat (out_iterations, out_escaped) is on the ports for one
//   cycle, marked by out_valid; the receiver cannot stall it. busy drops as
//   the beat appears, so the next point may start during that cycle; no
//   new point is taken while one is in flight.
//   Reset (rst_n low, synchronous) returns the sequencer to idle, drops any
//   point in flight and restores c = -0.7 + 0.26i and max_iter = 1000.
// ----------------------------------------------------------------------------
`include "julia_escape_time_top_defines.svh"

module julia_escape_time_top #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 28
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [jet_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               start,
  output logic                               busy,
  input  logic [31:0]                        in_z_real,
  input  logic [31:0]                        in_z_imag,
  output logic                               out_valid,
  output logic [jet_pkg::ITER_BITS-1:0]      out_iterations,
  output logic                               out_escaped
);

  jet_pkg::cfg_t                  cfg;
  jet_pkg::dp_cmd_t               cmd;
  jet_pkg::dp_status_t            status;
  logic [jet_pkg::ITER_BITS-1:0]  bound_iter;

  assign bound_iter = {1'b0, cfg.max_iter} + 17'd1;

  jet_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  jet_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .max_iter       (cfg.max_iter),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_iterations (out_iterations),
    .out_escaped    (out_escaped)
  );

  jet_dp #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk    (clk),
    .cmd    (cmd),
    .z_real (in_z_real),
    .z_imag (in_z_imag),
    .c_real (cfg.c_real),
    .c_imag (cfg.c_imag),
    .status (status)
  );

  `JET_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `JET_ASSERT_IMPLY(a_beat_idle, clk, rst_n, out_valid, !busy)
  `JET_ASSERT_IMPLY(a_bounded_count, clk, rst_n, out_valid && !out_escaped, out_iterations == bound_iter)
  `JET_ASSERT_IMPLY(a_escape_count, clk, rst_n, out_valid && out_escaped, out_iterations < bound_iter)

endmodule

// File: rtl/jet_cfg_regs.sv
// ----------------------------------------------------------------------------
// jet_cfg_regs
// APB register file holding the Julia constant and the iteration limit.
// ----------------------------------------------------------------------------
module jet_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [jet_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output jet_pkg::cfg_t                      cfg
);

  jet_pkg::cfg_t cfg_r;
  jet_pkg::cfg_t cfg_nxt;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        jet_pkg::REG_C_REAL:   cfg_nxt.c_real   = pwdata;
        jet_pkg::REG_C_IMAG:   cfg_nxt.c_imag   = pwdata;
        jet_pkg::REG_MAX_ITER: cfg_nxt.max_iter = pwdata[15:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      jet_pkg::REG_C_REAL:   prdata = cfg_r.c_real;
      jet_pkg::REG_C_IMAG:   prdata = cfg_r.c_imag;
      jet_pkg::REG_MAX_ITER: prdata = {16'd0, cfg_r.max_iter};
      default:               prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.c_real   <= jet_pkg::C_REAL_RESET;
      cfg_r.c_imag   <= jet_pkg::C_IMAG_RESET;
      cfg_r.max_iter <= jet_pkg::MAX_ITER_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: rtl/jet_dp.sv
// ----------------------------------------------------------------------------
// jet_dp
// Complex squaring datapath: z = z*z + c with saturation and escape test.
// ----------------------------------------------------------------------------
module jet_dp #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 28
) (
  input  logic                   clk,
  input  jet_pkg::dp_cmd_t       cmd,
  input  logic [31:0]            z_real,
  input  logic [31:0]            z_imag,
  input  logic [31:0]            c_real,
  input  logic [31:0]            c_imag,
  output jet_pkg::dp_status_t    status
);

  localparam int W  = WORD_BITS;
  localparam int SW = (W > 32) ? W : 32;
  localparam int CW = (2 * W > 2 * FRAC_BITS + 2) ? 2 * W + 2 : 2 * FRAC_BITS + 4;

  localparam logic [SW-1:0] IN_MAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [SW-1:0] IN_MIN = ~IN_MAX;
  localparam logic [CW-1:0] WD_MAX = {{(CW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [CW-1:0] WD_MIN = ~WD_MAX;
  localparam logic [CW-1:0] THR    = {{(CW-1){1'b0}}, 1'b1} << (2 * FRAC_BITS + 2);

  logic signed [W-1:0]    zr_r, zi_r;
  logic signed [W-1:0]    zr_nxt, zi_nxt;
  logic signed [W-1:0]    zr_in, zi_in, cr, ci;
  logic signed [2*W-1:0]  p_rr, p_ii, p_ri;
  logic signed [CW-1:0]   e_rr, e_ii, e_ri;
  logic signed [CW-1:0]   re_sum, im_sum, mag;

  function automatic logic [W-1:0] sat_in(input logic [31:0] v);
    logic signed [SW-1:0] x;
    x = $signed({{(SW-32){v[31]}}, v});
    if (x > $signed(IN_MAX))      sat_in = IN_MAX[W-1:0];
    else if (x < $signed(IN_MIN)) sat_in = IN_MIN[W-1:0];
    else                          sat_in = x[W-1:0];
  endfunction

  function automatic logic [W-1:0] sat_wd(input logic signed [CW-1:0] x);
    if (x > $signed(WD_MAX))      sat_wd = WD_MAX[W-1:0];
    else if (x < $signed(WD_MIN)) sat_wd = WD_MIN[W-1:0];
    else                          sat_wd = x[W-1:0];
  endfunction

  always_comb begin
    zr_in = $signed(sat_in(z_real));
    zi_in = $signed(sat_in(z_imag));
    cr    = $signed(sat_in(c_real));
    ci    = $signed(sat_in(c_imag));

    p_rr = zr_r * zr_r;
    p_ii = zi_r * zi_r;
    p_ri = zr_r * zi_r;

    e_rr = $signed({{(CW-2*W){p_rr[2*W-1]}}, p_rr});
    e_ii = $signed({{(CW-2*W){p_ii[2*W-1]}}, p_ii});
    e_ri = $signed({{(CW-2*W){p_ri[2*W-1]}}, p_ri});

    re_sum = ((e_rr - e_ii) >>> FRAC_BITS) + $signed({{(CW-W){cr[W-1]}}, cr});
    im_sum = ((e_ri <<< 1) >>> FRAC_BITS) + $signed({{(CW-W){ci[W-1]}}, ci});
    mag    = e_rr + e_ii;

    status.escape = mag > $signed(THR);

    zr_nxt = zr_r;
    zi_nxt = zi_r;
    if (cmd.load) begin
      zr_nxt = zr_in;
      zi_nxt = zi_in;
    end else if (cmd.step) begin
      zr_nxt = $signed(sat_wd(re_sum));
      zi_nxt = $signed(sat_wd(im_sum));
    end
  end

  always_ff @(posedge clk) begin
    zr_r <= zr_nxt;
    zi_r <= zi_nxt;
  end

endmodule

// File: rtl/jet_ctrl.sv
// ----------------------------------------------------------------------------
// jet_ctrl
// Iteration sequencer: loads a point, counts updates, emits the result beat.
// ----------------------------------------------------------------------------
module jet_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [15:0]                     max_iter,
  output jet_pkg::dp_cmd_t                cmd,
  input  jet_pkg::dp_status_t             status,
  output logic                            out_valid,
  output logic [jet_pkg::ITER_BITS-1:0]   out_iterations,
  output logic                            out_escaped
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                           state_r, state_nxt;
  logic [jet_pkg::ITER_BITS-1:0]  cnt_r, cnt_nxt;
  logic                           valid_r, valid_nxt;
  logic [jet_pkg::ITER_BITS-1:0]  iter_r, iter_nxt;
  logic                           esc_r, esc_nxt;
  logic [jet_pkg::ITER_BITS-1:0]  last_cnt;

  assign last_cnt       = {1'b0, max_iter} + {{(jet_pkg::ITER_BITS-1){1'b0}}, 1'b1};
  assign busy           = (state_r == ST_RUN);
  assign out_valid      = valid_r;
  assign out_iterations = iter_r;
  assign out_escaped    = esc_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    valid_nxt = 1'b0;
    iter_nxt  = iter_r;
    esc_nxt   = esc_r;
    cmd.load  = 1'b0;
    cmd.step  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if ((cnt_r != '0) && status.escape) begin
          valid_nxt = 1'b1;
          iter_nxt  = cnt_r - {{(jet_pkg::ITER_BITS-1){1'b0}}, 1'b1};
          esc_nxt   = 1'b1;
          state_nxt = ST_IDLE;
        end else if (cnt_r == last_cnt) begin
          valid_nxt = 1'b1;
          iter_nxt  = cnt_r;
          esc_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          cmd.step = 1'b1;
          cnt_nxt  = cnt_r + {{(jet_pkg::ITER_BITS-1){1'b0}}, 1'b1};
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    cnt_r  <= cnt_nxt;
    iter_r <= iter_nxt;
    esc_r  <= esc_nxt;
  end

endmodule
